@@ hdl/gftc_pkg.sv @@
// ----------------------------------------------------------------------------
// gftc_pkg
// Shared types and constants of the GSM frame time counter.
// ----------------------------------------------------------------------------
package gftc_pkg;

    localparam int FRAME_W = 22;
    localparam int SLOT_W  = 3;
    localparam int STEP_W  = 23;
    localparam int FUNC_W  = 2;
    localparam int ORDER_W = 2;

    // Width of the signed working values of the time update
    localparam int WORK_W  = 26;

    localparam logic [FRAME_W-1:0] HYPER_FRAMES = 22'd2715648;
    localparam logic signed [FRAME_W:0] HALF_HYPER = 23'sd1357824;
    localparam logic signed [FRAME_W:0] HYPER_S    = 23'sd2715648;

    // Whole hyperframe in timeslots
    localparam logic signed [WORK_W-1:0] SLOT_SPAN  = 26'sd21725184;
    localparam logic signed [WORK_W-1:0] HYPER_W    = 26'sd2715648;
    localparam logic signed [WORK_W-1:0] HYPER_W2   = 26'sd5431296;

    // Reciprocals for exact division of a 22-bit frame number
    localparam int PROD_W = 45;
    localparam logic [22:0] RECIP_26   = 23'd5162221;
    localparam int          SHIFT_26   = 27;
    localparam logic [22:0] RECIP_51   = 23'd5263441;
    localparam int          SHIFT_51   = 28;
    localparam logic [22:0] RECIP_1326 = 23'd6478081;
    localparam int          SHIFT_1326 = 33;

    localparam int Q26_W   = 17;
    localparam int Q51_W   = 16;
    localparam int Q1326_W = 11;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SLOT_STEP  = 2'd0,
        FUNC_FRAME_STEP = 2'd1,
        FUNC_LOAD       = 2'd2
    } t_func;

    typedef enum logic [ORDER_W-1:0] {
        ORDER_EQUAL   = 2'd0,
        ORDER_LESS    = 2'd1,
        ORDER_GREATER = 2'd2
    } t_order;

    // Load enables of the four pipeline register stages
    typedef struct packed {
        logic in_load;
        logic st_load;
        logic q_load;
        logic out_load;
    } t_pipe_en;

endpackage

@@ hdl/gftc_update.sv @@
// ----------------------------------------------------------------------------
// gftc_update
// Input register and time state: applies slot step, frame step or load.
// ----------------------------------------------------------------------------
module gftc_update (
    input  logic                               i_clk,
    input  gftc_pkg::t_pipe_en                 i_en,
    input  logic [gftc_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [gftc_pkg::STEP_W-1:0] i_step,
    input  logic [gftc_pkg::FRAME_W-1:0]       i_new_frame,
    input  logic [gftc_pkg::SLOT_W-1:0]        i_new_slot,
    input  logic [gftc_pkg::FRAME_W-1:0]       i_compare_frame,
    input  logic [gftc_pkg::SLOT_W-1:0]        i_compare_slot,
    input  logic                               i_rst_n,
    output logic [gftc_pkg::FRAME_W-1:0]       o_frame,
    output logic [gftc_pkg::SLOT_W-1:0]        o_slot,
    output logic [gftc_pkg::FRAME_W-1:0]       o_cmp_frame,
    output logic [gftc_pkg::SLOT_W-1:0]        o_cmp_slot
);
    import gftc_pkg::*;

    logic [FUNC_W-1:0]        r_func;
    logic signed [STEP_W-1:0] r_step;
    logic [FRAME_W-1:0]       r_new_frame;
    logic [SLOT_W-1:0]        r_new_slot;
    logic [FRAME_W-1:0]       r_in_cmp_frame;
    logic [SLOT_W-1:0]        r_in_cmp_slot;

    logic [FRAME_W-1:0]       r_frame;
    logic [SLOT_W-1:0]        r_slot;
    logic [FRAME_W-1:0]       r_cmp_frame;
    logic [SLOT_W-1:0]        r_cmp_slot;

    logic [FRAME_W-1:0]       n_frame;
    logic [SLOT_W-1:0]        n_slot;
    logic [FRAME_W-1:0]       n_cmp_frame;

    logic signed [WORK_W-1:0] slot_sum;
    logic signed [WORK_W-1:0] slot_wrap;
    logic signed [WORK_W-1:0] frame_sum;
    logic signed [WORK_W-1:0] frame_wrap;
    logic signed [WORK_W-1:0] cand_p2;
    logic signed [WORK_W-1:0] cand_p1;
    logic signed [WORK_W-1:0] cand_m1;
    logic signed [WORK_W-1:0] cand_m2;
    logic [FRAME_W-1:0]       load_frame;

    always_ff @(posedge i_clk) begin
        if (i_en.in_load) begin
            r_func         <= i_func;
            r_step         <= i_step;
            r_new_frame    <= i_new_frame;
            r_new_slot     <= i_new_slot;
            r_in_cmp_frame <= i_compare_frame;
            r_in_cmp_slot  <= i_compare_slot;
        end
    end

    // Timeslot step: move the time counted in slots, wrap once either way
    always_comb begin
        slot_sum = signed'({1'b0, r_frame, r_slot}) + WORK_W'(r_step);
        if (slot_sum < 0) begin
            slot_wrap = slot_sum + SLOT_SPAN;
        end else if (slot_sum >= SLOT_SPAN) begin
            slot_wrap = slot_sum - SLOT_SPAN;
        end else begin
            slot_wrap = slot_sum;
        end
    end

    // Frame step: the step can span up to two hyperframes either way
    always_comb begin
        frame_sum = signed'({{(WORK_W-FRAME_W){1'b0}}, r_frame}) + WORK_W'(r_step);
        cand_p2   = frame_sum + HYPER_W2;
        cand_p1   = frame_sum + HYPER_W;
        cand_m1   = frame_sum - HYPER_W;
        cand_m2   = frame_sum - HYPER_W2;
        if (cand_p1 < 0) begin
            frame_wrap = cand_p2;
        end else if (frame_sum < 0) begin
            frame_wrap = cand_p1;
        end else if (cand_m1 < 0) begin
            frame_wrap = frame_sum;
        end else if (cand_m2 < 0) begin
            frame_wrap = cand_m1;
        end else begin
            frame_wrap = cand_m2;
        end
    end

    always_comb begin
        load_frame  = (r_new_frame >= HYPER_FRAMES) ? r_new_frame - HYPER_FRAMES
                                                    : r_new_frame;
        n_cmp_frame = (r_in_cmp_frame >= HYPER_FRAMES) ? r_in_cmp_frame - HYPER_FRAMES
                                                       : r_in_cmp_frame;
    end

    always_comb begin
        n_frame = r_frame;
        n_slot  = r_slot;
        case (r_func)
            FUNC_SLOT_STEP: begin
                n_frame = slot_wrap[FRAME_W+SLOT_W-1:SLOT_W];
                n_slot  = slot_wrap[SLOT_W-1:0];
            end
            FUNC_FRAME_STEP: begin
                n_frame = frame_wrap[FRAME_W-1:0];
            end
            FUNC_LOAD: begin
                n_frame = load_frame;
                n_slot  = r_new_slot;
            end
            default: begin
                n_frame = r_frame;
                n_slot  = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_slot  <= '0;
        end else if (i_en.st_load) begin
            r_frame <= n_frame;
            r_slot  <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.st_load) begin
            r_cmp_frame <= n_cmp_frame;
            r_cmp_slot  <= r_in_cmp_slot;
        end
    end

    assign o_frame     = r_frame;
    assign o_slot      = r_slot;
    assign o_cmp_frame = r_cmp_frame;
    assign o_cmp_slot  = r_cmp_slot;

endmodule

@@ hdl/gftc_derive.sv @@
// ----------------------------------------------------------------------------
// gftc_derive
// Derived frame fields, compare delta and ordering, output registers.
// ----------------------------------------------------------------------------
module gftc_derive (
    input  logic                                i_clk,
    input  gftc_pkg::t_pipe_en                  i_en,
    input  logic [gftc_pkg::FRAME_W-1:0]        i_frame,
    input  logic [gftc_pkg::SLOT_W-1:0]         i_slot,
    input  logic [gftc_pkg::FRAME_W-1:0]        i_cmp_frame,
    input  logic [gftc_pkg::SLOT_W-1:0]         i_cmp_slot,
    output logic [gftc_pkg::FRAME_W-1:0]        o_frame_number,
    output logic [gftc_pkg::SLOT_W-1:0]         o_timeslot,
    output logic [10:0]                         o_t1_superframe,
    output logic [4:0]                          o_t2_value,
    output logic [5:0]                          o_t3_value,
    output logic [2:0]                          o_t3_prime,
    output logic [2:0]                          o_tc_value,
    output logic [4:0]                          o_t1_prime,
    output logic [5:0]                          o_t1_reduced,
    output logic signed [gftc_pkg::FRAME_W-1:0] o_frame_delta,
    output logic [gftc_pkg::ORDER_W-1:0]        o_order
);
    import gftc_pkg::*;

    logic [PROD_W-1:0]         prod_26;
    logic [PROD_W-1:0]         prod_51;
    logic [PROD_W-1:0]         prod_1326;
    logic signed [FRAME_W:0]   diff;
    logic signed [FRAME_W:0]   diff_wrap;
    t_order                    n_order;

    logic [FRAME_W-1:0]        r_q_frame;
    logic [SLOT_W-1:0]         r_q_slot;
    logic [Q26_W-1:0]          r_q26;
    logic [Q51_W-1:0]          r_q51;
    logic [Q1326_W-1:0]        r_q1326;
    logic signed [FRAME_W-1:0] r_q_delta;
    t_order                    r_q_order;

    logic [4:0]                n_t2;
    logic [5:0]                n_t3;
    logic [2:0]                n_t3_prime;

    logic [FRAME_W-1:0]        r_frame_number;
    logic [SLOT_W-1:0]         r_timeslot;
    logic [10:0]               r_t1;
    logic [4:0]                r_t2;
    logic [5:0]                r_t3;
    logic [2:0]                r_t3_prime;
    logic [2:0]                r_tc;
    logic [4:0]                r_t1_prime;
    logic [5:0]                r_t1_reduced;
    logic signed [FRAME_W-1:0] r_delta;
    t_order                    r_order;

    // Quotients by reciprocal multiply, exact over the 22-bit frame range
    always_comb begin
        prod_26   = PROD_W'(i_frame) * PROD_W'(RECIP_26);
        prod_51   = PROD_W'(i_frame) * PROD_W'(RECIP_51);
        prod_1326 = PROD_W'(i_frame) * PROD_W'(RECIP_1326);
    end

    // Frame difference wrapped into half a hyperframe
    always_comb begin
        diff = signed'({1'b0, i_frame}) - signed'({1'b0, i_cmp_frame});
        if (diff > HALF_HYPER) begin
            diff_wrap = diff - HYPER_S;
        end else if (diff < -HALF_HYPER) begin
            diff_wrap = diff + HYPER_S;
        end else begin
            diff_wrap = diff;
        end
    end

    always_comb begin
        if (i_frame == i_cmp_frame) begin
            if (i_slot == i_cmp_slot) begin
                n_order = ORDER_EQUAL;
            end else if (i_slot < i_cmp_slot) begin
                n_order = ORDER_LESS;
            end else begin
                n_order = ORDER_GREATER;
            end
        end else if (diff_wrap < 0) begin
            n_order = ORDER_LESS;
        end else begin
            n_order = ORDER_GREATER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.q_load) begin
            r_q_frame <= i_frame;
            r_q_slot  <= i_slot;
            r_q26     <= Q26_W'(prod_26 >> SHIFT_26);
            r_q51     <= Q51_W'(prod_51 >> SHIFT_51);
            r_q1326   <= Q1326_W'(prod_1326 >> SHIFT_1326);
            r_q_delta <= diff_wrap[FRAME_W-1:0];
            r_q_order <= n_order;
        end
    end

    // Remainders fit their low bits, so subtract in those bits only
    always_comb begin
        n_t2 = r_q_frame[4:0] - 5'(r_q26 * 17'd26);
        n_t3 = r_q_frame[5:0] - 6'(r_q51 * 16'd51);
        if (n_t3 inside {[6'd0:6'd10]}) begin
            n_t3_prime = 3'd0;
        end else if (n_t3 inside {[6'd11:6'd20]}) begin
            n_t3_prime = 3'd1;
        end else if (n_t3 inside {[6'd21:6'd30]}) begin
            n_t3_prime = 3'd2;
        end else if (n_t3 inside {[6'd31:6'd40]}) begin
            n_t3_prime = 3'd3;
        end else begin
            n_t3_prime = 3'd4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.out_load) begin
            r_frame_number <= r_q_frame;
            r_timeslot     <= r_q_slot;
            r_t1           <= r_q1326;
            r_t2           <= n_t2;
            r_t3           <= n_t3;
            r_t3_prime     <= n_t3_prime;
            r_tc           <= r_q51[2:0];
            r_t1_prime     <= r_q1326[4:0];
            r_t1_reduced   <= r_q1326[5:0];
            r_delta        <= r_q_delta;
            r_order        <= r_q_order;
        end
    end

    assign o_frame_number  = r_frame_number;
    assign o_timeslot      = r_timeslot;
    assign o_t1_superframe = r_t1;
    assign o_t2_value      = r_t2;
    assign o_t3_value      = r_t3;
    assign o_t3_prime      = r_t3_prime;
    assign o_tc_value      = r_tc;
    assign o_t1_prime      = r_t1_prime;
    assign o_t1_reduced    = r_t1_reduced;
    assign o_frame_delta   = r_delta;
    assign o_order         = r_order;

endmodule

@@ hdl/gsm_frame_time_counter.sv @@
// ----------------------------------------------------------------------------
// gsm_frame_time_counter: GSM TDMA frame number and timeslot counter
// Four register stages (input, time state, quotients, result); one item per
// cycle while the result is taken (i_ready high), else the chain stalls.
// Reset (synchronous, active low) clears the time to frame 0, slot 0.
// ----------------------------------------------------------------------------
//
// Pipeline:
//   stage 1  input register
//   stage 2  time state: slot step, frame step or load; compare time reduced
//   stage 3  reciprocal quotients by 26, 51 and 1326; compare delta and order
//   stage 4  result register: remainders and derived GSM fields
// Each stage loads when it is empty or the stage after it moves, so a full
// result register that is not taken stalls the chain while empty stages
// still fill. The time state is the stage 2 register itself, so each item
// sees the time left by the item before it.
module gsm_frame_time_counter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [gftc_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [gftc_pkg::STEP_W-1:0]  i_step,
    input  logic [gftc_pkg::FRAME_W-1:0]        i_new_frame,
    input  logic [gftc_pkg::SLOT_W-1:0]         i_new_slot,
    input  logic [gftc_pkg::FRAME_W-1:0]        i_compare_frame,
    input  logic [gftc_pkg::SLOT_W-1:0]         i_compare_slot,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [gftc_pkg::FRAME_W-1:0]        o_frame_number,
    output logic [gftc_pkg::SLOT_W-1:0]         o_timeslot,
    output logic [10:0]                         o_t1_superframe,
    output logic [4:0]                          o_t2_value,
    output logic [5:0]                          o_t3_value,
    output logic [2:0]                          o_t3_prime,
    output logic [2:0]                          o_tc_value,
    output logic [4:0]                          o_t1_prime,
    output logic [5:0]                          o_t1_reduced,
    output logic signed [gftc_pkg::FRAME_W-1:0] o_frame_delta,
    output logic [gftc_pkg::ORDER_W-1:0]        o_order
);
    import gftc_pkg::*;

    // Occupancy of each pipeline stage
    logic     r_v_in;
    logic     r_v_st;
    logic     r_v_q;
    logic     r_v_out;

    // Stage may advance: it is empty or its successor advances
    logic     adv_out;
    logic     adv_q;
    logic     adv_st;
    logic     adv_in;

    t_pipe_en en;

    logic [FRAME_W-1:0] st_frame;
    logic [SLOT_W-1:0]  st_slot;
    logic [FRAME_W-1:0] st_cmp_frame;
    logic [SLOT_W-1:0]  st_cmp_slot;

    always_comb begin
        adv_out = !r_v_out || i_ready;
        adv_q   = !r_v_q   || adv_out;
        adv_st  = !r_v_st  || adv_q;
        adv_in  = !r_v_in  || adv_st;

        // Load payload only where an item actually moves in
        en.in_load  = adv_in  && i_valid;
        en.st_load  = adv_st  && r_v_in;
        en.q_load   = adv_q   && r_v_st;
        en.out_load = adv_out && r_v_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in  <= 1'b0;
            r_v_st  <= 1'b0;
            r_v_q   <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            if (adv_in) begin
                r_v_in <= i_valid;
            end
            if (adv_st) begin
                r_v_st <= r_v_in;
            end
            if (adv_q) begin
                r_v_q <= r_v_st;
            end
            if (adv_out) begin
                r_v_out <= r_v_q;
            end
        end
    end

    assign o_ready = adv_in;
    assign o_valid = r_v_out;

    // Hold the input item and advance the time state
    gftc_update u_update (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_func          (i_func),
        .i_step          (i_step),
        .i_new_frame     (i_new_frame),
        .i_new_slot      (i_new_slot),
        .i_compare_frame (i_compare_frame),
        .i_compare_slot  (i_compare_slot),
        .i_rst_n         (i_rst_n),
        .o_frame         (st_frame),
        .o_slot          (st_slot),
        .o_cmp_frame     (st_cmp_frame),
        .o_cmp_slot      (st_cmp_slot)
    );

    // Derive the GSM fields and the comparison into the result register
    gftc_derive u_derive (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_frame         (st_frame),
        .i_slot          (st_slot),
        .i_cmp_frame     (st_cmp_frame),
        .i_cmp_slot      (st_cmp_slot),
        .o_frame_number  (o_frame_number),
        .o_timeslot      (o_timeslot),
        .o_t1_superframe (o_t1_superframe),
        .o_t2_value      (o_t2_value),
        .o_t3_value      (o_t3_value),
        .o_t3_prime      (o_t3_prime),
        .o_tc_value      (o_tc_value),
        .o_t1_prime      (o_t1_prime),
        .o_t1_reduced    (o_t1_reduced),
        .o_frame_delta   (o_frame_delta),
        .o_order         (o_order)
    );

endmodule
